FILE: hw/rtl/grid_tie_relay_guard_fsm_defines.svh
`ifndef GRID_TIE_RELAY_GUARD_FSM_DEFINES_SVH
`define GRID_TIE_RELAY_GUARD_FSM_DEFINES_SVH

// Implication in the same cycle.
`define GTRG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid tie relay guard: assertion failed");

// Implication in the next cycle.
`define GTRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid tie relay guard: assertion failed");

`endif

FILE: hw/rtl/gtrg_pkg.sv
package gtrg_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_NEEDED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOL_FRAMES = 2'd1;

  localparam logic [7:0] SYNC_NEEDED_RST = 8'd5;
  localparam logic [7:0] COOL_FRAMES_RST = 8'd3;
  localparam logic [6:0] FULL_PCT        = 7'd100;

  typedef enum logic [2:0] {
    MODE_WAIT   = 3'd0,
    MODE_SYNC   = 3'd1,
    MODE_EXPORT = 3'd2,
    MODE_TRIP   = 3'd3,
    MODE_COOL   = 3'd4
  } mode_t;

  localparam logic [2:0] CMD_OPEN   = 3'd0;
  localparam logic [2:0] CMD_HOLD   = 3'd1;
  localparam logic [2:0] CMD_TRACK  = 3'd2;
  localparam logic [2:0] CMD_CLOSE  = 3'd3;
  localparam logic [2:0] CMD_EXPORT = 3'd4;

  localparam logic [3:0] RSN_NONE  = 4'd0;
  localparam logic [3:0] RSN_RELAY = 4'd1;
  localparam logic [3:0] RSN_LOSS  = 4'd2;
  localparam logic [3:0] RSN_COOL  = 4'd3;
  localparam logic [4:0] RSN_FAULT_OFS = 5'd3;
  localparam logic [4:0] RSN_MAX       = 5'd15;

  localparam logic [2:0] Q_FAULT   = 3'd0;
  localparam logic [2:0] Q_RECOV   = 3'd1;
  localparam logic [2:0] Q_SEARCH  = 3'd2;
  localparam logic [2:0] Q_LOCKING = 3'd3;
  localparam logic [2:0] Q_DERATED = 3'd4;
  localparam logic [2:0] Q_LOCKED  = 3'd5;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] sync_cnt;
    logic [7:0] cool_cnt;
  } guard_state_t;

  typedef struct packed {
    logic       grid_live;
    logic       relay_feedback_closed;
    logic       grid_stable;
    logic [3:0] assessed_fault;
    logic [6:0] power_cap_pct;
  } frame_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] command;
    logic [3:0] reason;
    logic [2:0] quality;
    logic [6:0] export_limit_pct;
    logic [7:0] sync_frames;
    logic [7:0] cooldown_left;
    logic       relay_close_cmd;
  } result_t;

endpackage

FILE: hw/rtl/gtrg_step.sv
module gtrg_step
  import gtrg_pkg::*;
(
  input  guard_state_t state,
  input  frame_t       frame,
  input  logic [7:0]   sync_needed,
  input  logic [7:0]   cool_frames,
  output guard_state_t state_nxt,
  output result_t      result
);

  logic [6:0]   cap;
  logic [4:0]   fault_rsn;
  logic [7:0]   cool_dec;
  logic [7:0]   sync_inc;
  logic         do_trip;
  logic [3:0]   trip_rsn;
  logic [2:0]   cmd;
  logic [3:0]   rsn;
  logic [2:0]   qual;
  logic [6:0]   lim;
  logic         close;
  mode_t        mode_eff;
  guard_state_t nxt;

  assign cap       = (frame.power_cap_pct > FULL_PCT) ? FULL_PCT : frame.power_cap_pct;
  assign fault_rsn = {1'b0, frame.assessed_fault} + RSN_FAULT_OFS;
  assign cool_dec  = (state.cool_cnt != 8'd0) ? state.cool_cnt - 8'd1 : 8'd0;
  assign sync_inc  = (state.sync_cnt < sync_needed) ? state.sync_cnt + 8'd1 : state.sync_cnt;

  always_comb begin
    do_trip  = 1'b0;
    trip_rsn = RSN_NONE;
    if (state.mode == MODE_EXPORT && !frame.relay_feedback_closed) begin
      do_trip  = 1'b1;
      trip_rsn = RSN_RELAY;
    end else if (!frame.grid_live &&
                 (state.mode == MODE_SYNC || state.mode == MODE_EXPORT)) begin
      do_trip  = 1'b1;
      trip_rsn = RSN_LOSS;
    end else if (frame.assessed_fault != 4'd0) begin
      do_trip  = 1'b1;
      trip_rsn = (fault_rsn > RSN_MAX) ? RSN_MAX[3:0] : fault_rsn[3:0];
    end
  end

  always_comb begin
    nxt      = state;
    cmd      = CMD_OPEN;
    rsn      = RSN_NONE;
    qual     = Q_SEARCH;
    lim      = 7'd0;
    close    = 1'b0;
    mode_eff = state.mode;
    if (do_trip) begin
      nxt.mode     = MODE_TRIP;
      nxt.sync_cnt = 8'd0;
      nxt.cool_cnt = cool_frames;
      rsn          = trip_rsn;
      qual         = Q_FAULT;
    end else if (state.mode == MODE_TRIP) begin
      nxt.mode = MODE_COOL;
      cmd      = CMD_HOLD;
      rsn      = RSN_COOL;
      qual     = Q_RECOV;
    end else if (state.mode == MODE_COOL && cool_dec != 8'd0) begin
      nxt.cool_cnt = cool_dec;
      cmd          = CMD_HOLD;
      rsn          = RSN_COOL;
      qual         = Q_RECOV;
    end else begin
      // A finished cooldown falls through and is handled as wait grid.
      if (state.mode == MODE_COOL) begin
        mode_eff     = MODE_WAIT;
        nxt.mode     = MODE_WAIT;
        nxt.sync_cnt = 8'd0;
        nxt.cool_cnt = 8'd0;
      end
      if (!frame.grid_live) begin
        nxt.mode     = MODE_WAIT;
        nxt.sync_cnt = 8'd0;
      end else begin
        case (mode_eff)
          MODE_WAIT: begin
            if (frame.grid_stable) begin
              nxt.mode     = MODE_SYNC;
              nxt.sync_cnt = 8'd1;
              cmd          = CMD_TRACK;
              qual         = Q_LOCKING;
            end
          end
          MODE_SYNC: begin
            if (!frame.grid_stable) begin
              nxt.mode     = MODE_WAIT;
              nxt.sync_cnt = 8'd0;
            end else begin
              nxt.sync_cnt = sync_inc;
              if (sync_inc >= sync_needed) begin
                if (frame.relay_feedback_closed) begin
                  nxt.mode = MODE_EXPORT;
                  cmd      = CMD_EXPORT;
                  qual     = (cap < FULL_PCT) ? Q_DERATED : Q_LOCKED;
                  lim      = cap;
                  close    = 1'b1;
                end else begin
                  cmd   = CMD_CLOSE;
                  qual  = Q_LOCKING;
                  close = 1'b1;
                end
              end else begin
                cmd  = CMD_TRACK;
                qual = Q_LOCKING;
              end
            end
          end
          MODE_EXPORT: begin
            cmd   = CMD_EXPORT;
            qual  = (cap < FULL_PCT) ? Q_DERATED : Q_LOCKED;
            lim   = cap;
            close = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign state_nxt               = nxt;
  assign result.mode             = nxt.mode;
  assign result.command          = cmd;
  assign result.reason           = rsn;
  assign result.quality          = qual;
  assign result.export_limit_pct = lim;
  assign result.sync_frames      = nxt.sync_cnt;
  assign result.cooldown_left    = nxt.cool_cnt;
  assign result.relay_close_cmd  = close;

endmodule

FILE: hw/rtl/grid_tie_relay_guard_fsm.sv
// Channel  Direction  Item
// in_      slave      one measurement frame
// out_     master     one guard decision per frame
// cfg_     write      sync target (index 0), cooldown length (index 1)
//
// Each frame is decided in the cycle it is accepted and its result is held in one
// output register, so one item is taken every cycle while out_tready is high.
// in_tready drops only while a result waits in the output register and out_tready is low.
// rst_n is synchronous: mode returns to wait grid, counters clear, registers take 5 and 3.
`include "grid_tie_relay_guard_fsm_defines.svh"

module grid_tie_relay_guard_fsm
  import gtrg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // grid_live, relay_feedback_closed, grid_stable, assessed_fault[3:0],
  // power_cap_pct[6:0], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // mode[2:0], command[2:0], reason[3:0], quality[2:0], export_limit_pct[6:0],
  // sync_frames[7:0], cooldown_left[7:0], relay_close_cmd, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  guard_state_t            state_r;
  guard_state_t            state_nxt;
  logic [7:0]              sync_need_r;
  logic [7:0]              cool_frames_r;
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic [OUT_DATA_W-1:0]   out_data_nxt;
  logic                    in_accept;
  frame_t                  frame;
  result_t                 result;

  assign frame.grid_live             = in_tdata[0];
  assign frame.relay_feedback_closed = in_tdata[1];
  assign frame.grid_stable           = in_tdata[2];
  assign frame.assessed_fault        = in_tdata[6:3];
  assign frame.power_cap_pct         = in_tdata[13:7];

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  gtrg_step u_step (
    .state       (state_r),
    .frame       (frame),
    .sync_needed (sync_need_r),
    .cool_frames (cool_frames_r),
    .state_nxt   (state_nxt),
    .result      (result)
  );

  assign out_data_nxt = {3'd0, result.relay_close_cmd, result.cooldown_left,
                         result.sync_frames, result.export_limit_pct, result.quality,
                         result.reason, result.command, result.mode};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode     <= MODE_WAIT;
      state_r.sync_cnt <= 8'd0;
      state_r.cool_cnt <= 8'd0;
      sync_need_r      <= SYNC_NEEDED_RST;
      cool_frames_r    <= COOL_FRAMES_RST;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_wr_en && cfg_index == CFG_SYNC_NEEDED) begin
        sync_need_r <= cfg_data;
      end
      if (cfg_wr_en && cfg_index == CFG_COOL_FRAMES) begin
        cool_frames_r <= cfg_data;
      end
      if (in_accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `GTRG_ASSERT_IMPL(a_close_only_synced, clk, rst_n, out_tvalid && out_tdata[36],
                    out_tdata[2:0] == MODE_SYNC || out_tdata[2:0] == MODE_EXPORT)
  `GTRG_ASSERT_IMPL(a_power_only_export, clk, rst_n, out_tvalid && out_tdata[19:13] != 7'd0,
                    out_tdata[2:0] == MODE_EXPORT)
  `GTRG_ASSERT_IMPL(a_trip_clears_sync, clk, rst_n, state_r.mode == MODE_TRIP,
                    state_r.sync_cnt == 8'd0)
  `GTRG_ASSERT_NEXT(a_trip_leads_to_cool, clk, rst_n, in_accept && state_r.mode == MODE_TRIP,
                    state_r.mode == MODE_TRIP || state_r.mode == MODE_COOL)

endmodule

FILE: tb/tb_grid_tie_relay_guard_fsm.sv
`timescale 1ns / 1ps

module tb_grid_tie_relay_guard_fsm;
  import gtrg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grid_tie_relay_guard_fsm uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predicted guard state and register copies.
  mode_t      mode_now = MODE_WAIT;
  logic [7:0] sync_cnt = 8'd0;
  logic [7:0] cool_cnt = 8'd0;
  logic [7:0] need_frames = SYNC_NEEDED_RST;
  logic [7:0] cool_load = COOL_FRAMES_RST;

  result_t decisions_due[$];
  int      err_count = 0;
  int      frames_sent = 0;
  int      results_checked = 0;
  int      settings_used = 1;
  bit      tx_idle = 1'b1;
  bit      rx_idle = 1'b1;
  int      stall_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic result_t decide_frame(input frame_t f);
    result_t    d;
    logic [6:0] cap;
    logic [4:0] fault_rsn;
    logic [3:0] trip_rsn;
    bit         trip_hit;
    bit         go_on;
    d = '0;
    d.command = CMD_OPEN;
    d.reason = RSN_NONE;
    d.quality = Q_SEARCH;
    cap = (f.power_cap_pct > FULL_PCT) ? FULL_PCT : f.power_cap_pct;
    trip_hit = 1'b1;
    trip_rsn = RSN_NONE;
    if (mode_now == MODE_EXPORT && !f.relay_feedback_closed) begin
      trip_rsn = RSN_RELAY;
    end else if (!f.grid_live && (mode_now == MODE_SYNC || mode_now == MODE_EXPORT)) begin
      trip_rsn = RSN_LOSS;
    end else if (f.assessed_fault != 4'd0) begin
      fault_rsn = {1'b0, f.assessed_fault} + RSN_FAULT_OFS;
      if (fault_rsn > RSN_MAX) fault_rsn = RSN_MAX;
      trip_rsn = fault_rsn[3:0];
    end else begin
      trip_hit = 1'b0;
    end

    if (trip_hit) begin
      mode_now = MODE_TRIP;
      sync_cnt = 8'd0;
      cool_cnt = cool_load;
      d.quality = Q_FAULT;
      d.reason = trip_rsn;
    end else if (mode_now == MODE_TRIP) begin
      mode_now = MODE_COOL;
      d.command = CMD_HOLD;
      d.reason = RSN_COOL;
      d.quality = Q_RECOV;
    end else begin
      go_on = 1'b1;
      if (mode_now == MODE_COOL) begin
        if (cool_cnt > 8'd0) cool_cnt = cool_cnt - 8'd1;
        if (cool_cnt > 8'd0) begin
          d.command = CMD_HOLD;
          d.reason = RSN_COOL;
          d.quality = Q_RECOV;
          go_on = 1'b0;
        end else begin
          mode_now = MODE_WAIT;
          sync_cnt = 8'd0;
        end
      end
      if (go_on) begin
        if (!f.grid_live) begin
          mode_now = MODE_WAIT;
          sync_cnt = 8'd0;
        end else if (mode_now == MODE_WAIT) begin
          if (f.grid_stable) begin
            mode_now = MODE_SYNC;
            sync_cnt = 8'd1;
            d.command = CMD_TRACK;
            d.quality = Q_LOCKING;
          end
        end else if (mode_now == MODE_SYNC) begin
          if (!f.grid_stable) begin
            mode_now = MODE_WAIT;
            sync_cnt = 8'd0;
          end else begin
            if (sync_cnt < need_frames) sync_cnt = sync_cnt + 8'd1;
            d.quality = Q_LOCKING;
            if (sync_cnt >= need_frames) begin
              d.relay_close_cmd = 1'b1;
              if (f.relay_feedback_closed) begin
                mode_now = MODE_EXPORT;
                d.command = CMD_EXPORT;
                d.quality = (cap < FULL_PCT) ? Q_DERATED : Q_LOCKED;
                d.export_limit_pct = cap;
              end else begin
                d.command = CMD_CLOSE;
              end
            end else begin
              d.command = CMD_TRACK;
            end
          end
        end else if (mode_now == MODE_EXPORT) begin
          d.command = CMD_EXPORT;
          d.quality = (cap < FULL_PCT) ? Q_DERATED : Q_LOCKED;
          d.export_limit_pct = cap;
          d.relay_close_cmd = 1'b1;
        end
      end
    end
    d.mode = mode_now;
    d.sync_frames = sync_cnt;
    d.cooldown_left = cool_cnt;
    return d;
  endfunction

  function automatic frame_t frame_of(input bit present, input bit fb, input bit stable,
                                      input logic [3:0] fault, input logic [6:0] cap);
    frame_t f;
    f.grid_live = present;
    f.relay_feedback_closed = fb;
    f.grid_stable = stable;
    f.assessed_fault = fault;
    f.power_cap_pct = cap;
    return f;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!tx_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < 40) begin
      $display("Mismatch at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
    end
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch(name, got, want);
  endtask

  task automatic send_frame(input frame_t f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, f.power_cap_pct, f.assessed_fault, f.grid_stable,
                 f.relay_feedback_closed, f.grid_live};
    do @(posedge clk); while (!in_tready);
    decisions_due.push_back(decide_frame(f));
    frames_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (decisions_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_SYNC_NEEDED) need_frames = value;
    else if (idx == CFG_COOL_FRAMES) cool_load = value;
    @(posedge clk);
  endtask

  // Receiver back-pressure: mostly ready, short stalls and the odd long one.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 4) == 0) begin
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.mode = out_tdata[2:0];
      got.command = out_tdata[5:3];
      got.reason = out_tdata[9:6];
      got.quality = out_tdata[12:10];
      got.export_limit_pct = out_tdata[19:13];
      got.sync_frames = out_tdata[27:20];
      got.cooldown_left = out_tdata[35:28];
      got.relay_close_cmd = out_tdata[36];
      if (decisions_due.size() == 0) begin
        report_mismatch("unrequested result, mode", int'(got.mode), -1);
      end else begin
        want = decisions_due.pop_front();
        check_field("mode", int'(got.mode), int'(want.mode));
        check_field("command", int'(got.command), int'(want.command));
        check_field("reason", int'(got.reason), int'(want.reason));
        check_field("quality", int'(got.quality), int'(want.quality));
        check_field("export_limit_pct", int'(got.export_limit_pct),
                    int'(want.export_limit_pct));
        check_field("sync_frames", int'(got.sync_frames), int'(want.sync_frames));
        check_field("cooldown_left", int'(got.cooldown_left), int'(want.cooldown_left));
        check_field("relay_close_cmd", int'(got.relay_close_cmd),
                    int'(want.relay_close_cmd));
        results_checked++;
      end
    end
  end

  task automatic test_sync_and_export();
    send_frame(frame_of(1, 0, 0, 4'd0, 7'd100));
    send_frame(frame_of(0, 0, 1, 4'd0, 7'd100));
    repeat (5) send_frame(frame_of(1, 0, 1, 4'd0, 7'd100));
    send_frame(frame_of(1, 1, 1, 4'd0, 7'd127));
    send_frame(frame_of(1, 1, 0, 4'd0, 7'd0));
    send_frame(frame_of(1, 1, 1, 4'd0, 7'd101));
    send_frame(frame_of(1, 1, 1, 4'd0, 7'd99));
    send_frame(frame_of(1, 0, 1, 4'd0, 7'd50));
    repeat (4) send_frame(frame_of(1, 0, 1, 4'd0, 7'd100));
  endtask

  task automatic test_trip_causes();
    send_frame(frame_of(0, 0, 1, 4'd0, 7'd100));
    send_frame(frame_of(1, 0, 1, 4'd1, 7'd64));
    send_frame(frame_of(1, 0, 1, 4'd12, 7'd64));
    send_frame(frame_of(1, 1, 1, 4'd13, 7'd64));
    send_frame(frame_of(1, 1, 1, 4'd15, 7'd64));
  endtask

  task automatic test_register_edges();
    settle();
    write_reg(CFG_IDX_UNUSED_LO, 8'd0);
    write_reg(CFG_IDX_UNUSED_HI, 8'd0);
    write_reg(CFG_SYNC_NEEDED, 8'd0);
    write_reg(CFG_COOL_FRAMES, 8'd0);
    settings_used++;
    send_frame(frame_of(1, 0, 1, 4'd0, 7'd100));
    send_frame(frame_of(1, 0, 1, 4'd0, 7'd100));
    send_frame(frame_of(1, 1, 1, 4'd0, 7'd80));
    send_frame(frame_of(0, 1, 1, 4'd0, 7'd80));
    settle();
    write_reg(CFG_SYNC_NEEDED, 8'd10);
    settings_used++;
    repeat (7) send_frame(frame_of(1, 0, 1, 4'd0, 7'd100));
    settle();
    write_reg(CFG_SYNC_NEEDED, 8'd2);
    settings_used++;
    send_frame(frame_of(1, 0, 1, 4'd0, 7'd100));
    send_frame(frame_of(1, 1, 1, 4'd0, 7'd100));
    settle();
    write_reg(CFG_SYNC_NEEDED, 8'd255);
    write_reg(CFG_COOL_FRAMES, 8'd255);
    settings_used++;
    send_frame(frame_of(1, 1, 1, 4'd7, 7'd100));
    repeat (3) send_frame(frame_of(1, 1, 1, 4'd0, 7'd100));
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    int     r;
    if ($urandom_range(0, 9) == 0) begin
      f.grid_live = 1'($urandom_range(0, 1));
      f.relay_feedback_closed = 1'($urandom_range(0, 1));
      f.grid_stable = 1'($urandom_range(0, 1));
      f.assessed_fault = 4'($urandom_range(0, 15));
      f.power_cap_pct = 7'($urandom_range(0, 127));
      return f;
    end
    f.grid_live = $urandom_range(0, 39) != 0;
    f.grid_stable = $urandom_range(0, 24) != 0;
    f.assessed_fault = 4'(($urandom_range(0, 59) == 0) ? $urandom_range(1, 15) : 0);
    r = $urandom_range(0, 99);
    if (r < 70) f.power_cap_pct = 7'($urandom_range(0, 100));
    else if (r < 85) f.power_cap_pct = FULL_PCT;
    else f.power_cap_pct = 7'($urandom_range(101, 127));
    if (mode_now == MODE_EXPORT) f.relay_feedback_closed = $urandom_range(0, 49) != 0;
    else if (mode_now == MODE_SYNC) f.relay_feedback_closed = $urandom_range(0, 2) != 0;
    else f.relay_feedback_closed = 1'($urandom_range(0, 1));
    return f;
  endfunction

  task automatic test_random_traffic();
    logic [7:0] sync_set[6];
    logic [7:0] cool_set[6];
    int         run_len[6];
    sync_set = '{8'd5, 8'd1, 8'd0, 8'd255, 8'd3, 8'd2};
    cool_set = '{8'd3, 8'd0, 8'd1, 8'd255, 8'd6, 8'd2};
    run_len = '{200, 150, 150, 80, 170, 150};
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      if (ph == 4) begin
        sync_set[ph] = 8'($urandom_range(1, 12));
        cool_set[ph] = 8'($urandom_range(0, 12));
      end
      write_reg(CFG_SYNC_NEEDED, sync_set[ph]);
      write_reg(CFG_COOL_FRAMES, cool_set[ph]);
      settings_used++;
      tx_idle = (ph != 2);
      rx_idle = (ph != 2) && (ph != 5);
      repeat (run_len[ph]) send_frame(random_frame());
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_sync_and_export();
    test_trip_causes();
    test_register_edges();
    test_random_traffic();
    settle();
    $display("Sent %0d frames and checked %0d guard decisions.", frames_sent, results_checked);
    $display("Register settings used: %0d, including both extremes of each register.",
             settings_used);
    if (err_count == 0 && decisions_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
